@@ src/vgpre_pkg.sv @@
// Package for the voice gate with pre-roll: beat types, codes, controller state,
// and the command/status structs between controller and datapath. No dependencies.
package vgpre_pkg;

  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int MAX_REPLAY        = 16;
  localparam int REPLAY_W          = 5;   // holds 0..MAX_REPLAY
  localparam int HANDLE_W          = 16;
  localparam int LIMIT_W           = 5;
  localparam int BATCH_W           = 7;
  localparam int RUN_W             = 6;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 7;

  typedef enum logic [1:0] {
    KIND_CHUNK = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_END   = 2'd2,
    KIND_BATCH = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ATTACK_LIMIT   = 2'd0,
    REG_HANGOVER_LIMIT = 2'd1,
    REG_PREROLL_LEN    = 2'd2,
    REG_DOA_BATCH_LEN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                is_voice;
    logic [HANDLE_W-1:0] chunk_id;
  } in_beat_t;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] chunk_handle;
    logic                last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BATCH,
    ST_CHUNK,
    ST_END,
    ST_BEGIN,
    ST_READ,
    ST_REPLAY
  } state_t;

  typedef struct packed {
    logic  accept;      // input beat taken this cycle
    logic  load;        // load output register
    kind_t kind;
    logic  from_ring;   // chunk handle comes from ring read data
    logic  last;
    logic  rd_issue;    // read ring at replay pointer
    logic  rd_advance;  // step replay pointer and count
  } cmd_t;

  typedef struct packed {
    logic was_active;
    logic batch_due;
    logic end_due;
    logic begin_due;
    logic replay_zero;
    logic replay_one;
    logic out_free;
  } status_t;

endpackage

@@ src/vgpre_ctrl.sv @@
// Sequencing controller for the voice gate: walks the result list of one input beat.
// Depends on vgpre_pkg.
module vgpre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  vgpre_pkg::status_t status,
  output logic              in_ready,
  output vgpre_pkg::cmd_t   cmd
);
  import vgpre_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.kind       = KIND_CHUNK;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.was_active) begin
          state_next = status.batch_due ? ST_BATCH : ST_CHUNK;
        end else if (status.begin_due) begin
          state_next = ST_BEGIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BATCH: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_BATCH;
          state_next = ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_CHUNK;
          cmd.last   = !status.end_due;
          state_next = status.end_due ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_END;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_BEGIN: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_BEGIN;
          cmd.last   = status.replay_zero;
          state_next = status.replay_zero ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_REPLAY;
      end
      ST_REPLAY: begin
        if (status.out_free) begin
          cmd.load       = 1'b1;
          cmd.kind       = KIND_CHUNK;
          cmd.from_ring  = 1'b1;
          cmd.last       = status.replay_one;
          cmd.rd_advance = 1'b1;
          state_next     = status.replay_one ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/vgpre_dpath.sv @@
// Datapath for the voice gate: config registers, counters, history ring,
// replay pointer and output register. Depends on vgpre_pkg.
module vgpre_dpath #(
  parameter int HISTORY_DEPTH = vgpre_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vgpre_pkg::cmd_t                     cmd,
  output vgpre_pkg::status_t                  status,
  input  vgpre_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vgpre_pkg::out_beat_t                out_data,
  input  logic                                cfg_valid,
  input  logic [vgpre_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vgpre_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vgpre_pkg::*;

  localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > REPLAY_W) ? FILL_W : REPLAY_W;
  localparam int SUM_W  = PTR_W + 1;

  // config
  logic [LIMIT_W-1:0] attack_limit, hangover_limit, preroll_len;
  logic [BATCH_W-1:0] doa_batch_len;

  // control state
  logic               active;
  logic [RUN_W-1:0]   run_count;
  logic [BATCH_W-1:0] batch_count;
  logic [FILL_W-1:0]  history_fill;
  logic [PTR_W-1:0]   write_pointer;
  logic               was_active, batch_due, end_due, begin_due;
  logic [REPLAY_W-1:0] remain;
  logic [PTR_W-1:0]   rd_idx;

  // payload
  logic [HANDLE_W-1:0] handle;
  logic [HANDLE_W-1:0] rd_data;
  logic [HANDLE_W-1:0] history_ring [HISTORY_DEPTH];

  // next values at accept
  logic               active_next;
  logic [RUN_W-1:0]   run_count_next, run_inc;
  logic [BATCH_W-1:0] batch_count_next, batch_inc, batch_lim;
  logic               batch_hit, end_hit, begin_hit;
  logic [FILL_W-1:0]  history_fill_next;
  logic [PTR_W-1:0]   write_pointer_next;
  logic [REPLAY_W-1:0] pre_clamp, replay_cnt;
  logic [SUM_W-1:0]   start_sum;
  logic [PTR_W-1:0]   start_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_limit   <= LIMIT_W'(5);
      hangover_limit <= LIMIT_W'(5);
      preroll_len    <= LIMIT_W'(10);
      doa_batch_len  <= BATCH_W'(20);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK_LIMIT:   attack_limit   <= cfg_data[LIMIT_W-1:0];
        REG_HANGOVER_LIMIT: hangover_limit <= cfg_data[LIMIT_W-1:0];
        REG_PREROLL_LEN:    preroll_len    <= cfg_data[LIMIT_W-1:0];
        REG_DOA_BATCH_LEN:  doa_batch_len  <= cfg_data[BATCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    batch_lim = (doa_batch_len == '0) ? BATCH_W'(1) : doa_batch_len;
    batch_inc = batch_count + BATCH_W'(1);
    batch_hit = (batch_inc >= batch_lim);
    run_inc   = (run_count == {RUN_W{1'b1}}) ? run_count : run_count + RUN_W'(1);

    active_next      = active;
    run_count_next   = run_count;
    batch_count_next = batch_count;
    end_hit          = 1'b0;
    begin_hit        = 1'b0;
    if (active) begin
      batch_count_next = batch_hit ? '0 : batch_inc;
      if (in_data.is_voice) begin
        run_count_next = '0;
      end else begin
        run_count_next = run_inc;
        if (run_inc > RUN_W'(hangover_limit)) begin
          end_hit        = 1'b1;
          active_next    = 1'b0;
          run_count_next = '0;
        end
      end
    end else if (in_data.is_voice) begin
      run_count_next = run_inc;
      if (run_inc > RUN_W'(attack_limit)) begin
        begin_hit      = 1'b1;
        active_next    = 1'b1;
        run_count_next = '0;
      end
    end else begin
      run_count_next = '0;
    end

    history_fill_next = (history_fill < FILL_W'(HISTORY_DEPTH)) ?
                        history_fill + FILL_W'(1) : history_fill;
    write_pointer_next = (write_pointer == PTR_W'(HISTORY_DEPTH - 1)) ?
                         '0 : write_pointer + PTR_W'(1);

    // replay count: min(preroll_len, MAX_REPLAY, handles stored)
    pre_clamp  = (preroll_len > REPLAY_W'(MAX_REPLAY)) ? REPLAY_W'(MAX_REPLAY)
                                                     : REPLAY_W'(preroll_len);
    replay_cnt = (CMP_W'(pre_clamp) > CMP_W'(history_fill_next)) ?
                 REPLAY_W'(history_fill_next) : pre_clamp;

    // oldest replayed slot, modulo depth
    start_sum = SUM_W'(write_pointer_next) + SUM_W'(HISTORY_DEPTH) - SUM_W'(replay_cnt);
    start_idx = (start_sum >= SUM_W'(HISTORY_DEPTH)) ?
                PTR_W'(start_sum - SUM_W'(HISTORY_DEPTH)) : PTR_W'(start_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      run_count     <= '0;
      batch_count   <= '0;
      history_fill  <= '0;
      write_pointer <= '0;
      was_active    <= 1'b0;
      batch_due     <= 1'b0;
      end_due       <= 1'b0;
      begin_due     <= 1'b0;
      remain        <= '0;
      rd_idx        <= '0;
    end else if (cmd.accept) begin
      active        <= active_next;
      run_count     <= run_count_next;
      batch_count   <= batch_count_next;
      history_fill  <= history_fill_next;
      write_pointer <= write_pointer_next;
      was_active    <= active;
      batch_due     <= active && batch_hit;
      end_due       <= end_hit;
      begin_due     <= begin_hit;
      remain        <= replay_cnt;
      rd_idx        <= start_idx;
    end else if (cmd.rd_advance) begin
      remain <= remain - REPLAY_W'(1);
      rd_idx <= (rd_idx == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : rd_idx + PTR_W'(1);
    end
  end

  // history ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      history_ring[write_pointer] <= in_data.chunk_id;
      handle                      <= in_data.chunk_id;
    end
    if (cmd.rd_issue) begin
      rd_data <= history_ring[rd_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.kind         <= cmd.kind;
      out_data.last         <= cmd.last;
      out_data.chunk_handle <= (cmd.kind != KIND_CHUNK) ? '0 :
                               (cmd.from_ring ? rd_data : handle);
    end
  end

  always_comb begin
    status.was_active  = was_active;
    status.batch_due   = batch_due;
    status.end_due     = end_due;
    status.begin_due   = begin_due;
    status.replay_zero = (remain == '0);
    status.replay_one  = (remain == REPLAY_W'(1));
    status.out_free    = !out_valid || out_ready;
  end

endmodule

@@ src/voice_gate_with_preroll_unit.sv @@
// Top level of the voice gate with hangover and pre-roll replay.
// Depends on vgpre_pkg, vgpre_ctrl and vgpre_dpath.
//
//   channel | signals                               | payload
//   --------+---------------------------------------+---------------------------------
//   input   | in_valid / in_ready / in_data         | is_voice, chunk_id
//   output  | out_valid / out_ready / out_data      | kind, chunk_handle, last
//   config  | cfg_valid / cfg_ready / cfg_index/data| register index, write data
//
// One input beat at a time: an accept state and a decode state, then one state
// per tag or live chunk and two per replayed handle (ring read, then output
// load).
// Synchronous reset clears control state; no clearing pass, the ring is only
// read at slots written since reset.
// A stalled output holds the controller in its current result state.
// cfg_ready is always high.
module voice_gate_with_preroll_unit #(
  parameter int HISTORY_DEPTH = vgpre_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vgpre_pkg::in_beat_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vgpre_pkg::out_beat_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vgpre_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vgpre_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vgpre_pkg::*;

  cmd_t    cmd;
  status_t status;

  // the user must issue writes only while idle (the block does not enforce it); the port never stalls
  assign cfg_ready = 1'b1;

  // controller: idle and decode states, one state per result kind, plus ring read/replay pair
  vgpre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath: counters decided at accept, ring, output register
  vgpre_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ src/vgpre_checker.sv @@
// Port-level checks for the voice gate, bound to the top level.
// Depends on vgpre_pkg.
module vgpre_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input vgpre_pkg::out_beat_t out_data
);
  import vgpre_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // tags carry a zero handle
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_CHUNK |-> out_data.chunk_handle == '0)
    else $error("tag beat with nonzero handle");

  // end tag closes the list, batch tag never does
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.kind != KIND_END || out_data.last) &&
                  (out_data.kind != KIND_BATCH || !out_data.last))
    else $error("last flag wrong for tag kind");

endmodule

bind voice_gate_with_preroll_unit vgpre_checker u_chk (.*);

@@ verif/tb_voice_gate_with_preroll_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for voice_gate_with_preroll_unit: queued stimulus, a beat-level
// predictor of the gate, and an in-order result check. Depends on vgpre_pkg and the RTL.
module tb_voice_gate_with_preroll_unit;
  import vgpre_pkg::*;

  localparam int DEPTH       = DEF_HISTORY_DEPTH;
  localparam int SETTLE      = 40;    // quiet cycles before a register write
  localparam int TAIL_CYCLES = 40;    // drain time after the last expected beat
  localparam int STUCK_LIMIT = 1000;  // cycles with no handshake at all
  localparam int RAND_ITEMS  = 130;
  localparam int PHASE_ITEMS = 18;

  // what the sender queue can hold: an audio chunk, a register write, or a hold
  // until every expected result has drained
  typedef enum logic [1:0] {
    STIM_CHUNK,
    STIM_CFG,
    STIM_DRAIN
  } stim_op_t;

  typedef struct packed {
    stim_op_t              op;
    in_beat_t              beat;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_beat_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  always #10 clk = ~clk;

  voice_gate_with_preroll_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Stimulus plan and the generator's view of the current settings
  // ---------------------------------------------------------------------------
  stim_t chunk_plan_q[$];
  int    planned_chunks = 0;
  int    plan_atk, plan_hang;

  // ---------------------------------------------------------------------------
  // Gate predictor state: its own copy of the registers and the gate
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] atk_cfg, hang_cfg, pre_cfg;
  logic [BATCH_W-1:0] batch_cfg;
  logic               gate_open;
  logic [RUN_W-1:0]   run_len;
  logic [15:0]        ring [DEPTH];
  int                 ring_fill, ring_wr;
  logic [BATCH_W-1:0] batch_acc;

  out_beat_t gated_out_q[$];   // results still owed by the block, oldest first

  // shared between the monitor (writer) and the driver (reader, next edge)
  logic settled = 1'b0;

  int errors      = 0;
  int chunks_in   = 0;
  int results_out = 0;
  int segs_seen   = 0;
  int batch_seen  = 0;
  int cfg_writes  = 0;
  int settings    = 0;

  function automatic out_beat_t make_beat(kind_t k, logic [15:0] h);
    out_beat_t r;
    r.kind         = k;
    r.chunk_handle = h;
    r.last         = 1'b0;
    return r;
  endfunction

  // Work out every result caused by one accepted chunk and queue them.
  task automatic gate_chunk(input in_beat_t b);
    out_beat_t burst[$];
    out_beat_t r;
    int        lim, cnt, rd;
    // every handle lands in the ring first, so the replay ends with this one
    ring[ring_wr] = b.chunk_id;
    ring_wr = (ring_wr + 1) % DEPTH;
    if (ring_fill < DEPTH) ring_fill++;
    if (gate_open) begin
      // zero batch length behaves as one; the test is reached or passed
      lim = (batch_cfg == '0) ? 1 : int'(batch_cfg);
      batch_acc = batch_acc + 1'b1;
      if (int'(batch_acc) >= lim) begin
        batch_acc = '0;
        burst.push_back(make_beat(KIND_BATCH, '0));
      end
      burst.push_back(make_beat(KIND_CHUNK, b.chunk_id));
      if (b.is_voice) begin
        run_len = '0;
      end else begin
        if (run_len != '1) run_len++;
        if (run_len > RUN_W'(hang_cfg)) begin
          gate_open = 1'b0;
          run_len   = '0;
          burst.push_back(make_beat(KIND_END, '0));
        end
      end
    end else if (b.is_voice) begin
      if (run_len != '1) run_len++;
      if (run_len > RUN_W'(atk_cfg)) begin
        gate_open = 1'b1;
        run_len   = '0;
        burst.push_back(make_beat(KIND_BEGIN, '0));
        // replay clipped to MAX_REPLAY and to what has been stored so far
        cnt = (int'(pre_cfg) > MAX_REPLAY) ? MAX_REPLAY : int'(pre_cfg);
        if (cnt > ring_fill) cnt = ring_fill;
        rd = (ring_wr + DEPTH - cnt) % DEPTH;
        for (int i = 0; i < cnt; i++) begin
          burst.push_back(make_beat(KIND_CHUNK, ring[rd]));
          rd = (rd + 1) % DEPTH;
        end
      end
    end else begin
      run_len = '0;
    end
    foreach (burst[i]) begin
      r      = burst[i];
      r.last = (i == burst.size() - 1);
      gated_out_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Plan builders used by the initial block
  // ---------------------------------------------------------------------------
  task automatic push_chunk(input logic voice, input logic [15:0] id);
    stim_t s;
    s               = '0;
    s.op            = STIM_CHUNK;
    s.beat.is_voice = voice;
    s.beat.chunk_id = id;
    chunk_plan_q.push_back(s);
    planned_chunks++;
  endtask

  task automatic push_cfg(input cfg_reg_t idx, input int val);
    stim_t s;
    s     = '0;
    s.op  = STIM_CFG;
    s.idx = idx;
    // 5-bit registers get junk in the top data bits, the block must drop it
    if (idx == REG_DOA_BATCH_LEN) s.data = CFG_DATA_W'(val);
    else s.data = {2'($urandom_range(0, 3)), 5'(val)};
    chunk_plan_q.push_back(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s    = '0;
    s.op = STIM_DRAIN;
    chunk_plan_q.push_back(s);
  endtask

  task automatic set_config(input int atk, input int hang, input int pre, input int blen);
    push_cfg(REG_ATTACK_LIMIT, atk);
    push_cfg(REG_HANGOVER_LIMIT, hang);
    push_cfg(REG_PREROLL_LEN, pre);
    push_cfg(REG_DOA_BATCH_LEN, blen);
    plan_atk  = atk;
    plan_hang = hang;
    settings++;
  endtask

  // Mostly a clean segment: attack run, active body, hangover run. Some lead-in
  // noise and aborted attack runs keep the idle side honest.
  task automatic plan_segment();
    repeat ($urandom_range(0, 2)) push_chunk(1'b0, 16'($urandom()));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) push_chunk(1'($urandom_range(0, 1)), 16'($urandom()));
    end
    if (plan_atk > 0 && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, plan_atk)) push_chunk(1'b1, 16'($urandom()));
      push_chunk(1'b0, 16'($urandom()));
    end
    repeat (plan_atk + 1 + $urandom_range(0, 2)) push_chunk(1'b1, 16'($urandom()));
    repeat ($urandom_range(0, 4)) push_chunk(1'($urandom_range(0, 1)), 16'($urandom()));
    repeat (plan_hang + 1) push_chunk(1'b0, 16'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of chunk beats with random gaps; register writes and holds
  // only once the block has gone quiet with nothing owed.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_proc
    logic                  nxt_valid;
    in_beat_t              nxt_data;
    logic                  nxt_cfg;
    logic [CFG_INDEX_W-1:0] nxt_idx;
    logic [CFG_DATA_W-1:0] nxt_cdata;
    stim_t                 head;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      nxt_cfg   = cfg_valid;
      nxt_idx   = cfg_index;
      nxt_cdata = cfg_data;
      if (in_valid && in_ready) nxt_valid = 1'b0;
      if (cfg_valid && cfg_ready) nxt_cfg = 1'b0;
      if (!nxt_valid && !nxt_cfg && chunk_plan_q.size() != 0) begin
        head = chunk_plan_q[0];
        case (head.op)
          STIM_CHUNK: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              nxt_valid = 1'b1;
              nxt_data  = head.beat;
              chunk_plan_q.delete(0);
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
              end
            end
          end
          STIM_CFG: begin
            // in_valid low now means the last chunk was taken at an earlier edge,
            // so settled already reflects it
            if (settled && !in_valid && !cfg_valid) begin
              nxt_cfg   = 1'b1;
              nxt_idx   = head.idx;
              nxt_cdata = head.data;
              chunk_plan_q.delete(0);
            end
          end
          default: begin
            if (settled && !in_valid && !cfg_valid) chunk_plan_q.delete(0);
          end
        endcase
      end
      in_valid  <= nxt_valid;
      in_data   <= nxt_data;
      cfg_valid <= nxt_cfg;
      cfg_index <= nxt_idx;
      cfg_data  <= nxt_cdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: each time the low seven bits of rx_tick wrap to zero, picks at random
  // among always ready, random stalls, and one-in-five acceptance.
  // ---------------------------------------------------------------------------
  logic [15:0] rx_tick = '0;
  logic [1:0]  rx_mode = '0;

  always @(posedge clk) begin : sink_proc
    if (rst) begin
      out_ready <= 1'b0;
      rx_tick   <= '0;
      rx_mode   <= '0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 2));
      case (rx_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (rx_tick % 5 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result beats in order, feed the predictor with accepted
  // chunk beats and register writes, and run the watchdog.
  // ---------------------------------------------------------------------------
  int quiet_cnt = 0;
  int stuck_cnt = 0;

  always @(posedge clk) begin : mon_proc
    out_beat_t want;
    logic      moved;
    if (rst) begin
      atk_cfg   = 5'd5;
      hang_cfg  = 5'd5;
      pre_cfg   = 5'd10;
      batch_cfg = 7'd20;
      gate_open = 1'b0;
      run_len   = '0;
      ring_fill = 0;
      ring_wr   = 0;
      batch_acc = '0;
      quiet_cnt = 0;
      stuck_cnt = 0;
      settled  <= 1'b0;
    end else begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        results_out++;
        if (out_data.kind == KIND_BEGIN) segs_seen++;
        if (out_data.kind == KIND_BATCH) batch_seen++;
        if (gated_out_q.size() == 0) begin
          $display("%0t: result beat with none expected: kind %0d handle %h last %b",
                   $time, out_data.kind, out_data.chunk_handle, out_data.last);
          errors++;
        end else begin
          want = gated_out_q[0];
          gated_out_q.delete(0);
          if (out_data.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
            errors++;
          end
          if (out_data.chunk_handle !== want.chunk_handle) begin
            $display("%0t: chunk_handle expected %h actual %h",
                     $time, want.chunk_handle, out_data.chunk_handle);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        chunks_in++;
        gate_chunk(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_reg_t'(cfg_index))
          REG_ATTACK_LIMIT:   atk_cfg   = cfg_data[LIMIT_W-1:0];
          REG_HANGOVER_LIMIT: hang_cfg  = cfg_data[LIMIT_W-1:0];
          REG_PREROLL_LEN:    pre_cfg   = cfg_data[LIMIT_W-1:0];
          REG_DOA_BATCH_LEN:  batch_cfg = cfg_data[BATCH_W-1:0];
          default: ;
        endcase
      end
      // register writes do not disturb the datapath, so they leave the quiet count
      quiet_cnt = moved ? 0 : quiet_cnt + 1;
      settled  <= (gated_out_q.size() == 0) && (quiet_cnt >= SETTLE);
      stuck_cnt = (moved || (cfg_valid && cfg_ready)) ? 0 : stuck_cnt + 1;
      if (stuck_cnt >= STUCK_LIMIT) begin
        $display("%0t: watchdog, no handshake for %0d cycles, %0d results owed",
                 $time, stuck_cnt, gated_out_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Plan: directed corner cases, then random phases; then wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin : plan_proc
    int p;
    int rand_base;
    int start;

    // attack after two voice chunks, no hangover, oversized pre-roll, zero batch
    set_config(1, 0, 31, 0);
    push_chunk(1'b0, 16'h0000);   // idle silence
    push_chunk(1'b1, 16'hFFFF);   // voice, still below the attack limit
    push_chunk(1'b1, 16'h1234);   // opens; only three handles stored so far
    push_chunk(1'b1, 16'hAAAA);   // active, batch mark on every chunk
    push_chunk(1'b0, 16'h5555);   // first silent chunk ends the segment
    // pre-roll off: the opening chunk gives just the begin tag
    set_config(0, 0, 0, 0);
    push_chunk(1'b1, 16'h8001);
    push_chunk(1'b0, 16'h7FFE);
    // wrap the ring and replay a full sixteen
    set_config(2, 2, 16, 3);
    repeat (8) push_chunk(1'b0, 16'($urandom()));
    repeat (3) push_chunk(1'b1, 16'($urandom()));
    push_chunk(1'b1, 16'h00FF);
    repeat (3) push_chunk(1'b0, 16'($urandom()));

    rand_base = planned_chunks;
    p = 0;
    while (planned_chunks - rand_base < RAND_ITEMS) begin
      case (p % 6)
        0: set_config($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 31),
                      $urandom_range(0, 8));
        1: set_config(0, 31, 16, 64);     // long segment, batch count builds up
        2: set_config($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(10, 20),
                      $urandom_range(2, 5));
        3: set_config(31, 0, 0, 1);
        4: set_config($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(17, 31),
                      $urandom_range(64, 127));
        default: set_config($urandom_range(0, 2), $urandom_range(0, 8),
                            $urandom_range(1, 16), $urandom_range(0, 3));
      endcase
      start = planned_chunks;
      plan_segment();
      push_drain();   // sender holds until every owed result is out
      while (planned_chunks - start < PHASE_ITEMS) plan_segment();
      p++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (chunk_plan_q.size() != 0 || in_valid || cfg_valid) @(negedge clk);
    while (gated_out_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run: %0d chunks in, %0d results out, %0d segments opened, %0d batch marks",
             chunks_in, results_out, segs_seen, batch_seen);
    $display("run: %0d register writes across %0d settings", cfg_writes, settings);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
